FILE: design/clefia_pkg.sv
// Package for the CLEFIA-128 cipher unit: S-box tables, F-functions,
// constant generator step and shared types. No dependencies.
`timescale 1ns / 1ps
package clefia_pkg;

  localparam logic [15:0] CON_P    = 16'hb7e1;
  localparam logic [15:0] CON_Q    = 16'h243f;
  localparam logic [15:0] CON_POLY = 16'ha830;
  localparam logic [15:0] CON_IV   = 16'h428a;
  localparam int unsigned KEY_ROUNDS = 12;

  typedef enum logic [1:0] {
    ST_KEYNET,
    ST_RKEY,
    ST_READY
  } ks_state_t;

  // Control that the sequencer hands to the GFN4 datapath.
  typedef struct packed {
    logic        load;
    logic        fwd;
    logic        no_swap;
    logic [31:0] rk0;
    logic [31:0] rk1;
  } cell_ctrl_t;

  localparam logic [3:0] SS0 [16] = '{4'he,4'h6,4'hc,4'ha,4'h8,4'h7,4'h2,4'hf,
                                      4'hb,4'h1,4'h4,4'h0,4'h5,4'h9,4'hd,4'h3};
  localparam logic [3:0] SS1 [16] = '{4'h6,4'h4,4'h0,4'hd,4'h2,4'hb,4'ha,4'h3,
                                      4'h9,4'hc,4'he,4'hf,4'h8,4'h7,4'h5,4'h1};
  localparam logic [3:0] SS2 [16] = '{4'hb,4'h8,4'h5,4'he,4'ha,4'h6,4'h4,4'hc,
                                      4'hf,4'h7,4'h2,4'h3,4'h1,4'h0,4'hd,4'h9};
  localparam logic [3:0] SS3 [16] = '{4'ha,4'h2,4'h6,4'hd,4'h3,4'h4,4'h5,4'he,
                                      4'h0,4'h7,4'h8,4'h9,4'hb,4'hf,4'hc,4'h1};

  localparam logic [7:0] SBOX1 [256] = '{
    8'h6c,8'hda,8'hc3,8'he9,8'h4e,8'h9d,8'h0a,8'h3d,8'hb8,8'h36,8'hb4,8'h38,8'h13,8'h34,8'h0c,8'hd9,
    8'hbf,8'h74,8'h94,8'h8f,8'hb7,8'h9c,8'he5,8'hdc,8'h9e,8'h07,8'h49,8'h4f,8'h98,8'h2c,8'hb0,8'h93,
    8'h12,8'heb,8'hcd,8'hb3,8'h92,8'he7,8'h41,8'h60,8'he3,8'h21,8'h27,8'h3b,8'he6,8'h19,8'hd2,8'h0e,
    8'h91,8'h11,8'hc7,8'h3f,8'h2a,8'h8e,8'ha1,8'hbc,8'h2b,8'hc8,8'hc5,8'h0f,8'h5b,8'hf3,8'h87,8'h8b,
    8'hfb,8'hf5,8'hde,8'h20,8'hc6,8'ha7,8'h84,8'hce,8'hd8,8'h65,8'h51,8'hc9,8'ha4,8'hef,8'h43,8'h53,
    8'h25,8'h5d,8'h9b,8'h31,8'he8,8'h3e,8'h0d,8'hd7,8'h80,8'hff,8'h69,8'h8a,8'hba,8'h0b,8'h73,8'h5c,
    8'h6e,8'h54,8'h15,8'h62,8'hf6,8'h35,8'h30,8'h52,8'ha3,8'h16,8'hd3,8'h28,8'h32,8'hfa,8'haa,8'h5e,
    8'hcf,8'hea,8'hed,8'h78,8'h33,8'h58,8'h09,8'h7b,8'h63,8'hc0,8'hc1,8'h46,8'h1e,8'hdf,8'ha9,8'h99,
    8'h55,8'h04,8'hc4,8'h86,8'h39,8'h77,8'h82,8'hec,8'h40,8'h18,8'h90,8'h97,8'h59,8'hdd,8'h83,8'h1f,
    8'h9a,8'h37,8'h06,8'h24,8'h64,8'h7c,8'ha5,8'h56,8'h48,8'h08,8'h85,8'hd0,8'h61,8'h26,8'hca,8'h6f,
    8'h7e,8'h6a,8'hb6,8'h71,8'ha0,8'h70,8'h05,8'hd1,8'h45,8'h8c,8'h23,8'h1c,8'hf0,8'hee,8'h89,8'had,
    8'h7a,8'h4b,8'hc2,8'h2f,8'hdb,8'h5a,8'h4d,8'h76,8'h67,8'h17,8'h2d,8'hf4,8'hcb,8'hb1,8'h4a,8'ha8,
    8'hb5,8'h22,8'h47,8'h3a,8'hd5,8'h10,8'h4c,8'h72,8'hcc,8'h00,8'hf9,8'he0,8'hfd,8'he2,8'hfe,8'hae,
    8'hf8,8'h5f,8'hab,8'hf1,8'h1b,8'h42,8'h81,8'hd6,8'hbe,8'h44,8'h29,8'ha6,8'h57,8'hb9,8'haf,8'hf2,
    8'hd4,8'h75,8'h66,8'hbb,8'h68,8'h9f,8'h50,8'h02,8'h01,8'h3c,8'h7f,8'h8d,8'h1a,8'h88,8'hbd,8'hac,
    8'hf7,8'he4,8'h79,8'h96,8'ha2,8'hfc,8'h6d,8'hb2,8'h6b,8'h03,8'he1,8'h2e,8'h7d,8'h14,8'h95,8'h1d};

  function automatic logic [3:0] nib_x2(input logic [3:0] a);
    nib_x2 = {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
  endfunction

  function automatic logic [7:0] sb0(input logic [7:0] x);
    logic [3:0] a, b, u0, u1;
    a  = SS0[x[7:4]];
    b  = SS1[x[3:0]];
    u0 = a ^ nib_x2(b);
    u1 = b ^ nib_x2(a);
    sb0 = {SS2[u0], SS3[u1]};
  endfunction

  function automatic logic [7:0] gx2(input logic [7:0] a);
    gx2 = {a[6:0], 1'b0} ^ (a[7] ? 8'h1d : 8'h00);
  endfunction

  function automatic logic [31:0] f0(input logic [31:0] rk, input logic [31:0] x);
    logic [31:0] t;
    logic [7:0] b0, b1, b2, b3;
    t  = rk ^ x;
    b0 = sb0(t[31:24]);
    b1 = SBOX1[t[23:16]];
    b2 = sb0(t[15:8]);
    b3 = SBOX1[t[7:0]];
    f0 = {b0 ^ gx2(b1) ^ gx2(gx2(b2)) ^ gx2(gx2(b3)) ^ gx2(b3),
          gx2(b0) ^ b1 ^ gx2(gx2(b2)) ^ gx2(b2) ^ gx2(gx2(b3)),
          gx2(gx2(b0)) ^ gx2(gx2(b1)) ^ gx2(b1) ^ b2 ^ gx2(b3),
          gx2(gx2(b0)) ^ gx2(b0) ^ gx2(gx2(b1)) ^ gx2(b2) ^ b3};
  endfunction

  function automatic logic [31:0] f1(input logic [31:0] rk, input logic [31:0] x);
    logic [31:0] t;
    logic [7:0] b0, b1, b2, b3;
    t  = rk ^ x;
    b0 = SBOX1[t[31:24]];
    b1 = sb0(t[23:16]);
    b2 = SBOX1[t[15:8]];
    b3 = sb0(t[7:0]);
    f1 = {b0 ^ gx2(gx2(gx2(b1))) ^ gx2(b2) ^ gx2(gx2(gx2(b3))) ^ gx2(b3),
          gx2(gx2(gx2(b0))) ^ b1 ^ gx2(gx2(gx2(b2))) ^ gx2(b2) ^ gx2(b3),
          gx2(b0) ^ gx2(gx2(gx2(b1))) ^ gx2(b1) ^ b2 ^ gx2(gx2(gx2(b3))),
          gx2(gx2(gx2(b0))) ^ gx2(b0) ^ gx2(b1) ^ gx2(gx2(gx2(b2))) ^ b3};
  endfunction

  // Two constant words from the generator value, and the next value.
  function automatic logic [63:0] con_pair(input logic [15:0] t);
    con_pair = {t ^ CON_P, ~{t[14:0], t[15]}, ~t ^ CON_Q, {t[7:0], t[15:8]}};
  endfunction

  function automatic logic [15:0] con_step(input logic [15:0] t);
    logic [15:0] u;
    u = t[0] ? (t ^ CON_POLY) : t;
    con_step = {u[0], u[15:1]};
  endfunction

endpackage

FILE: design/clefia_if.sv
// Valid/ready channel interfaces for the CLEFIA-128 cipher unit.
// Depends on nothing.
`timescale 1ns / 1ps
interface clefia_in_if;
  logic        valid;
  logic        ready;
  logic        decrypt;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, decrypt, block_high, block_low, input ready);
  modport sink (input valid, decrypt, block_high, block_low, output ready);
endinterface

interface clefia_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

FILE: design/clefia_cell.sv
// One GFN4 round cell: holds one 32-bit word of the state row and hands
// the updated word to its neighbor.
`timescale 1ns / 1ps
module clefia_cell (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [31:0] load_word,
  input  logic [31:0] from_nb,
  output logic [31:0] word
);
  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
    end else if (step) begin
      word <= from_nb;
    end
  end
endmodule

FILE: design/clefia_net.sv
// GFN4 datapath: a ring of four word cells with the two F-functions between
// them, one round per cycle while step is high, forward or inverse. Uses clefia_pkg, clefia_cell.
`timescale 1ns / 1ps
module clefia_net (
  input  logic                  clk,
  input  clefia_pkg::cell_ctrl_t ctrl,
  input  logic                  step,
  input  logic [127:0]          load_data,
  output logic [127:0]          state
);
  logic [31:0] w [4];
  logic [31:0] y1, y3;
  logic [31:0] nb [4];

  always_comb begin
    y1 = w[1] ^ clefia_pkg::f0(ctrl.rk0, w[0]);
    y3 = w[3] ^ clefia_pkg::f1(ctrl.rk1, w[2]);
    if (ctrl.no_swap) begin
      nb[0] = w[0]; nb[1] = y1; nb[2] = w[2]; nb[3] = y3;
    end else if (ctrl.fwd) begin
      nb[0] = y1; nb[1] = w[2]; nb[2] = y3; nb[3] = w[0];
    end else begin
      nb[0] = y3; nb[1] = w[0]; nb[2] = y1; nb[3] = w[2];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_cell
    clefia_cell u_cell (
      .clk       (clk),
      .load      (ctrl.load),
      .step      (step),
      .load_word (load_data[127-32*i -: 32]),
      .from_nb   (nb[i]),
      .word      (w[i])
    );
  end

  assign state = {w[0], w[1], w[2], w[3]};
endmodule

FILE: design/clefia128_block_cipher_unit.sv
// CLEFIA-128 cipher unit. Each block passes through load, ROUNDS rounds on the single
// ring and capture; a new block is accepted only after the last one is captured.
// A result waiting at the output holds the ring at capture.
// Reset (synchronous, active high) clears the key and starts the schedule: a load
// cycle, 12 key rounds and ceil(ROUNDS/2) round-key steps, during which no block is
// accepted. A key write restarts the same schedule.
`timescale 1ns / 1ps
module clefia128_block_cipher_unit #(
  parameter int ROUNDS = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  clefia_in_if.sink          in_ch,
  clefia_out_if.source       out_ch
);
  localparam int RK_WORDS = 2 * ROUNDS;
  localparam int KS_STEPS = (RK_WORDS + 3) / 4;
  localparam int RW = $clog2(ROUNDS + 2);
  localparam int KW = $clog2(KS_STEPS + 1);
  localparam int RKW = $clog2(2 * KS_STEPS);
  localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
  localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;

  logic [63:0] key_high, key_low;
  // One entry per round: the F0 key in the upper word, the F1 key in the lower.
  logic [63:0] rk_mem [2 * KS_STEPS];
  logic [15:0] con_t, con_t1;
  logic [63:0] cp, cp1;
  logic [RW-1:0] rnd, ri;
  logic [KW-1:0] ks_cnt;
  logic [127:0] lval, lbase, lx;
  logic busy, res_valid, dec, cap;
  logic [127:0] res;
  logic [127:0] net_state, load_data;
  logic step;
  logic wr, key_wr;
  clefia_pkg::ks_state_t st, st_next;
  clefia_pkg::cell_ctrl_t ctrl;
  logic [RKW-1:0] ra;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_comb begin
    case (paddr)
      ADDR_KEY_HIGH: prdata = key_high;
      ADDR_KEY_LOW:  prdata = key_low;
      default:       prdata = 64'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= 64'h0;
      key_low  <= 64'h0;
    end else if (wr && paddr == ADDR_KEY_HIGH) begin
      key_high <= pwdata;
    end else if (wr && paddr == ADDR_KEY_LOW) begin
      key_low <= pwdata;
    end
  end

  assign key_wr = wr && (paddr == ADDR_KEY_HIGH || paddr == ADDR_KEY_LOW);

  // Schedule sequencer.
  always_ff @(posedge clk) begin
    if (rst || key_wr) begin
      st <= clefia_pkg::ST_KEYNET;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      clefia_pkg::ST_KEYNET:
        if (rnd == RW'(clefia_pkg::KEY_ROUNDS)) st_next = clefia_pkg::ST_RKEY;
      clefia_pkg::ST_RKEY:
        if (ks_cnt == KW'(KS_STEPS - 1)) st_next = clefia_pkg::ST_READY;
      default: st_next = st;
    endcase
  end

  // The constants are consumed in generator order: one pair per key round,
  // then two pairs per round-key step.
  assign con_t1 = clefia_pkg::con_step(con_t);
  assign cp  = clefia_pkg::con_pair(con_t);
  assign cp1 = clefia_pkg::con_pair(con_t1);

  always_ff @(posedge clk) begin
    if (rst || key_wr) begin
      con_t <= clefia_pkg::CON_IV;
    end else if (st == clefia_pkg::ST_KEYNET && rnd != '0) begin
      con_t <= con_t1;
    end else if (st == clefia_pkg::ST_RKEY) begin
      con_t <= clefia_pkg::con_step(con_t1);
    end
  end

  // Round counter: rnd 0 is the load cycle, then rounds 1..N, then the
  // capture cycle N+1.
  always_ff @(posedge clk) begin
    if (rst || key_wr) begin
      rnd  <= '0;
      busy <= 1'b0;
    end else if (st == clefia_pkg::ST_KEYNET) begin
      rnd <= rnd + 1'b1;
    end else if (st == clefia_pkg::ST_RKEY) begin
      rnd <= '0;
    end else if (in_ch.valid && in_ch.ready) begin
      busy <= 1'b1;
      rnd  <= RW'(1);
    end else if (busy) begin
      if (rnd != RW'(ROUNDS + 1)) begin
        rnd <= rnd + 1'b1;
      end else if (cap) begin
        busy <= 1'b0;
        rnd  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) dec <= in_ch.decrypt;
  end

  // Round key selection for round rnd (1-based).
  assign ri = dec ? RW'(ROUNDS) - rnd : rnd - 1'b1;
  assign ra = RKW'(ri);

  always_comb begin
    ctrl = '0;
    step = 1'b0;
    load_data = {key_high, key_low};
    if (st == clefia_pkg::ST_KEYNET) begin
      ctrl.fwd = 1'b1;
      if (rnd == '0) begin
        ctrl.load = 1'b1;
      end else begin
        step = 1'b1;
        ctrl.rk0 = cp[63:32];
        ctrl.rk1 = cp[31:0];
        ctrl.no_swap = (rnd == RW'(clefia_pkg::KEY_ROUNDS));
      end
    end else if (in_ch.valid && in_ch.ready) begin
      ctrl.load = 1'b1;
      if (in_ch.decrypt) begin
        load_data = {in_ch.block_high[63:32], in_ch.block_high[31:0] ^ key_low[63:32],
                     in_ch.block_low[63:32], in_ch.block_low[31:0] ^ key_low[31:0]};
      end else begin
        load_data = {in_ch.block_high[63:32], in_ch.block_high[31:0] ^ key_high[63:32],
                     in_ch.block_low[63:32], in_ch.block_low[31:0] ^ key_high[31:0]};
      end
    end else if (busy && rnd != RW'(ROUNDS + 1)) begin
      step = 1'b1;
      ctrl.fwd = !dec;
      ctrl.rk0 = rk_mem[ra][63:32];
      ctrl.rk1 = rk_mem[ra][31:0];
      ctrl.no_swap = (rnd == RW'(ROUNDS));
    end
  end

  clefia_net u_net (
    .clk       (clk),
    .ctrl      (ctrl),
    .step      (step),
    .load_data (load_data),
    .state     (net_state)
  );

  // Round key generation, one step of four words per cycle. The first step
  // takes L straight from the ring.
  always_comb begin
    lbase = (ks_cnt == '0) ? net_state : lval;
    lx = lbase ^ {cp, cp1};
    if (ks_cnt[0]) lx = lx ^ {key_high, key_low};
  end

  always_ff @(posedge clk) begin
    if (rst || key_wr) begin
      ks_cnt <= '0;
    end else if (st == clefia_pkg::ST_RKEY) begin
      ks_cnt <= ks_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st == clefia_pkg::ST_RKEY) begin
      lval <= {lbase[120:64], lbase[6:0], lbase[127:121], lbase[63:7]};
      rk_mem[RKW'({ks_cnt, 1'b0})] <= lx[127:64];
      rk_mem[RKW'({ks_cnt, 1'b1})] <= lx[63:0];
    end
  end

  // Output register.
  assign cap = busy && (rnd == RW'(ROUNDS + 1)) && (!res_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst || key_wr) begin
      res_valid <= 1'b0;
    end else if (cap) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      if (dec) begin
        res <= {net_state[127:96], net_state[95:64] ^ key_high[63:32], net_state[63:32],
                net_state[31:0] ^ key_high[31:0]};
      end else begin
        res <= {net_state[127:96], net_state[95:64] ^ key_low[63:32], net_state[63:32],
                net_state[31:0] ^ key_low[31:0]};
      end
    end
  end

  assign in_ch.ready = (st == clefia_pkg::ST_READY) && !busy;
  assign out_ch.valid = res_valid;
  assign out_ch.result_high = res[127:64];
  assign out_ch.result_low = res[63:0];

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ch.ready) else $error("input taken while rounds run");
  a_result_after_rounds: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(busy)) else $error("result without rounds");
  a_ready_needs_keys: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> st == clefia_pkg::ST_READY) else $error("ready before schedule");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_high)
    && $stable(out_ch.result_low)) else $error("waiting result changed");
`endif
endmodule
